FILE: hw/rtl/sha256_pkg.sv
// Package: SHA-256 constants, types and round functions.
package sha256_pkg;

    localparam int unsigned NumRounds = 64;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned DigestWords = 8;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } out_item_t;

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        begin
            case (idx)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic word_t init_h(input logic [2:0] idx);
        word_t h;
        begin
            case (idx)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: hw/rtl/sha256_if.sv
// Interfaces: valid/ready channels for input bytes and digest words.
interface sha256_in_if;
    import sha256_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
    import sha256_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/sha256_stream_hash.sv
// Top level: byte-stream SHA-256 with one shared round unit.
//
//  channel   dir  payload
//  in_ch     in   data_byte, byte_present, end_of_message
//  out_ch    out  digest_word, word_number, last_word
//
// A plain byte is only written into the buffer; the 64th byte of a block also
// starts a compression: the block is streamed from the buffer into the schedule
// window, the rounds run and the result is folded into the chaining words. An
// end transaction adds the padding fill (one byte per cycle), one or two
// compressions and eight output transactions. in_ch is not ready while a
// block is in work. rst_n resets control and chaining state at once; the
// buffer is never cleared. Output stalls hold the word.
module sha256_stream_hash (
    input  logic               clk,
    input  logic               rst_n,
    sha256_in_if.sink          in_ch,
    sha256_out_if.source       out_ch
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [7:0]  buf_mem [BlockBytes];
    logic [6:0]  fill_reg;       // pad pointer, may reach 64
    logic [63:0] bits_reg;
    logic [63:0] total_reg;
    word_t       h_reg [DigestWords];
    word_t       v_reg [DigestWords];
    word_t       w_reg [16];
    logic [6:0]  rnd_reg;
    logic        eom_reg;        // message closing in progress
    logic        len_reg;        // current pad block carries the length
    logic        mark_reg;       // 0x80 still to be written
    logic [2:0]  oidx_reg;
    logic [1:0]  bsel_reg;

    logic [7:0]  rd_byte;
    logic [5:0]  rd_addr;

    // round datapath
    word_t s0, s1, wnew, wcur, t1, t2;
    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        wcur = w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
            + round_k(rnd_reg[5:0]) + wcur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // pad byte for the current pointer
    logic [7:0] pad_byte;
    logic [5:0] pad_pos;
    always_comb
    begin
        pad_pos = fill_reg[5:0];
        if (mark_reg)
            pad_byte = 8'h80;
        else if (len_reg && pad_pos >= 6'd56)
            pad_byte = total_reg[8 * (63 - int'(pad_pos)) +: 8];
        else
            pad_byte = 8'h00;
    end

    // buffer write
    logic       wr_en;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = fill_reg[5:0];
        wr_data = in_ch.payload.data_byte;
        if (state_reg == ST_IDLE && in_ch.valid && in_ch.payload.byte_present)
            wr_en = 1'b1;
        else if (state_reg == ST_PAD && fill_reg < 7'd64)
        begin
            wr_en = 1'b1;
            wr_data = pad_byte;
        end
    end

    assign rd_addr = rnd_reg[5:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_addr] <= wr_data;
        rd_byte <= buf_mem[rd_addr];
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_EMIT);
    assign out_ch.payload.digest_word = h_reg[oidx_reg];
    assign out_ch.payload.word_number = oidx_reg;
    assign out_ch.payload.last_word = (oidx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            bits_reg <= '0;
            total_reg <= '0;
            rnd_reg <= '0;
            eom_reg <= 1'b0;
            len_reg <= 1'b0;
            oidx_reg <= '0;
            bsel_reg <= '0;
            for (int i = 0; i < DigestWords; i++)
            begin
                h_reg[i] <= init_h(3'(i));
                v_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
                w_reg[i] <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        logic [6:0] nf;
                        nf = fill_reg + 7'(in_ch.payload.byte_present);
                        eom_reg <= in_ch.payload.end_of_message;
                        if (in_ch.payload.end_of_message)
                            total_reg <= bits_reg + {54'd0, nf, 3'd0};
                        if (nf == 7'd64)
                        begin
                            fill_reg <= '0;
                            bits_reg <= bits_reg + 64'd512;
                            len_reg <= 1'b0;
                            rnd_reg <= '0;
                            bsel_reg <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else if (in_ch.payload.end_of_message)
                        begin
                            fill_reg <= nf;
                            state_reg <= ST_PAD;
                            // length fits behind the 0x80 only below byte 56
                            len_reg <= (nf < 7'd56);
                        end
                        else
                            fill_reg <= nf;
                    end
                end
                ST_PAD:
                begin
                    if (fill_reg < 7'd64)
                        fill_reg <= fill_reg + 7'd1;
                    else
                    begin
                        fill_reg <= '0;
                        rnd_reg <= '0;
                        bsel_reg <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    // stream 64 bytes into the schedule window, 4 per word
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg != 7'd0)
                    begin
                        w_reg[15] <= {w_reg[15][23:0], rd_byte};
                        bsel_reg <= bsel_reg + 2'd1;
                        // advance the window once the previous word is complete
                        if (bsel_reg == 2'd0 && rnd_reg != 7'd1)
                        begin
                            for (int i = 0; i < 15; i++)
                                w_reg[i] <= w_reg[i + 1];
                        end
                    end
                    if (rnd_reg == 7'd64)
                    begin
                        rnd_reg <= '0;
                        for (int i = 0; i < DigestWords; i++)
                            v_reg[i] <= h_reg[i];
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= wnew;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd63)
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < DigestWords; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    rnd_reg <= '0;
                    if (!eom_reg)
                        state_reg <= ST_IDLE;
                    else if (len_reg)
                    begin
                        oidx_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        len_reg <= 1'b1;
                        state_reg <= ST_PAD;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < DigestWords; i++)
                                h_reg[i] <= init_h(3'(i));
                            bits_reg <= '0;
                            fill_reg <= '0;
                            eom_reg <= 1'b0;
                            len_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // pad control: hold the 0x80 until the first pad write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mark_reg <= 1'b0;
        else if (state_reg == ST_IDLE && in_ch.valid && in_ch.payload.end_of_message)
            mark_reg <= 1'b1;
        else if (state_reg == ST_PAD && fill_reg < 7'd64)
            mark_reg <= 1'b0;
    end

endmodule

FILE: bench/testbench.sv
// Testbench for the byte-stream SHA-256 block: predicts digests and checks output words.
import sha256_pkg::*;

class digest_scoreboard;
    out_item_t   expected_words[$];
    logic [7:0]  msg_block[64];
    int unsigned msg_fill;
    logic [63:0] msg_bits;
    word_t       chain[8];
    int          mismatches;

    function new();
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        msg_fill = 0;
        msg_bits = '0;
        for (int i = 0; i < 8; i++)
            chain[i] = init_h(i[2:0]);
    endfunction

    function word_t ror32(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        word_t w[64];
        word_t v[8];
        word_t t1;
        word_t t2;
        for (int r = 0; r < 16; r++)
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        v = chain;
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(r[5:0]) + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endfunction

    function void note_input(in_item_t it);
        logic [63:0] total;
        int unsigned i;
        out_item_t   o;
        if (it.byte_present)
        begin
            msg_block[msg_fill] = it.data_byte;
            msg_fill++;
            if (msg_fill == 64)
            begin
                compress();
                msg_bits += 512;
                msg_fill = 0;
            end
        end
        if (!it.end_of_message)
            return;
        i = msg_fill;
        total = msg_bits + 64'(i) * 8;
        msg_block[i] = 8'h80;
        i++;
        if (i > 56)
        begin
            while (i < 64) begin msg_block[i] = 8'h00; i++; end
            compress();
            i = 0;
        end
        while (i < 56) begin msg_block[i] = 8'h00; i++; end
        for (int b = 0; b < 8; b++)
            msg_block[63 - b] = total[8*b +: 8];
        compress();
        for (int b = 0; b < 8; b++)
        begin
            o.digest_word = chain[b];
            o.word_number = b[2:0];
            o.last_word = (b == 7);
            expected_words.push_back(o);
        end
        restart();
    endfunction

    function void check_word(out_item_t got);
        out_item_t want;
        if (expected_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digest word %h #%0d last %b",
                         got.digest_word, got.word_number, got.last_word);
            return;
        end
        want = expected_words.pop_front();
        if (got.digest_word !== want.digest_word || got.word_number !== want.word_number
            || got.last_word !== want.last_word)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("digest word mismatch: expected %h #%0d last %b, got %h #%0d last %b",
                         want.digest_word, want.word_number, want.last_word,
                         got.digest_word, got.word_number, got.last_word);
        end
    endfunction
endclass

module testbench;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   send_idle_pct = 38;
    int   recv_idle_pct = 54;
    int   items_sent = 0;

    sha256_in_if  in_ch();
    sha256_out_if out_ch();
    digest_scoreboard board;

    sha256_stream_hash i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
    end

    // Sample both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_input(in_ch.payload);
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_word(out_ch.payload);
    end

    // Receiver stalls at random.
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_item(input logic [7:0] b, input logic pres, input logic eom);
        in_item_t it;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        it.data_byte = b;
        it.byte_present = pres;
        it.end_of_message = eom;
        in_ch.payload <= it;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_message(input int len, input bit noise);
        for (int i = 0; i < len; i++)
        begin
            if (noise && $urandom_range(9) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(1))
                send_item(8'($urandom_range(255)), 1'b1, 1'b1);
            else
                send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        end
        if (len == 0 || !in_ch.payload.end_of_message)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic drain();
        while (board.expected_words.size() != 0) @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty message, no-op item, extreme bytes, block edges.
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b0, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1) begin send_idle_pct = 54; recv_idle_pct = 38; end
            if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            if (phase == 0)
            begin
                // 56 bytes forces the extra padding block; 64 completes on end.
                send_message(56, 1'b0);
                send_message(64, 1'b0);
            end
            while (items_sent < 130 * (phase + 1) - (phase == 2 ? 20 : 0))
            begin
                case ($urandom_range(4))
                    0: send_message(int'($urandom_range(3)), 1'b1);
                    1: send_message(int'($urandom_range(54, 57)), 1'b1);
                    2: send_message(int'($urandom_range(63, 65)), 1'b1);
                    default: send_message(int'($urandom_range(20)), 1'b1);
                endcase
            end
            drain();
        end
        repeat (200) @(posedge clk);
        if (board.mismatches == 0 && board.expected_words.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
